[sv/arc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the square-root step for the repetition counter.
package arc_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int FILTER_FRAC_BITS = 8;
	localparam int COUNT_BITS       = 16;

	localparam int FIELD_W  = 16;
	localparam int RAW_W    = FIELD_W + SAMPLE_BITS;
	localparam int AXIS_BITS = SAMPLE_BITS + FILTER_FRAC_BITS;
	localparam int MAG_FRAC = (AXIS_BITS > 31) ? (31 - SAMPLE_BITS) : FILTER_FRAC_BITS;
	localparam int MAG_DROP = FILTER_FRAC_BITS - MAG_FRAC;
	localparam int A_W      = AXIS_BITS - MAG_DROP;
	localparam int SQ_W     = 2 * A_W;
	localparam int SUM_W    = SQ_W + 2;

	// root unit: two root bits per cycle
	localparam int SQRT_CYC   = (A_W + 2) / 2;
	localparam int RT_W       = 2 * SQRT_CYC;
	localparam int RAD_W      = 2 * RT_W;
	localparam int REM_W      = RT_W + 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_CYC);
	localparam int MAGF_W     = RT_W - MAG_FRAC;
	localparam int CMP_W      = MAGF_W + FIELD_W;
	localparam int CNT_EXT_W  = COUNT_BITS + FIELD_W;

	localparam int GAIN_W    = 9;
	localparam int GAIN_FRAC = 8;
	localparam int GAIN_ONE  = 256;
	localparam int PROD_W    = AXIS_BITS + 1 + GAIN_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN       = 3'd0,
		REG_LIFT       = 3'd1,
		REG_LOWER      = 3'd2,
		REG_REST_LOW   = 3'd3,
		REG_REST_HIGH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LIFT  = 2'd1,
		PH_LOWER = 2'd2
	} phase_t;

	typedef struct packed {
		logic load;    // new sample accepted
		logic first;   // first sample since reset: load filter directly
		logic square;  // register the squared filter value
	} lane_ctrl_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [RT_W-1:0]  root;
	} sqrt_acc_t;

	// one restoring digit of the integer square root
	function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] bits);
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		sqrt_acc_t        res;
		cur   = {acc.rem[REM_W-3:0], bits};
		trial = {acc.root, 2'b01};
		if (cur >= trial) begin
			res.rem  = cur - trial;
			res.root = {acc.root[RT_W-2:0], 1'b1};
		end else begin
			res.rem  = cur;
			res.root = {acc.root[RT_W-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

[sv/accel_rep_counter.sv]
`timescale 1ns / 1ps
// Top level: config registers, three axis lanes, merge, root unit and phase machine.
//
// Input channel (in_valid/in_ready) takes one three-axis sample per word;
// output channel (out_valid/out_ready) returns one word per sample with the
// repetition total, filtered magnitude and motion phase after that sample.
// The block holds one sample at a time: in_ready is high only while no
// sample is in flight. When a result is issued, in_ready returns in that
// same cycle. The pace is set by the square-root unit, which resolves two
// root bits per cycle; before it the sample is squared and the squares
// summed, and after it the root is picked up and the phase and count
// updated as the result word is written.
// The result sits in an output register, so a new sample is taken while a
// finished word waits; if the receiver still stalls when the next result is
// ready, the block holds that result and in_ready stays low.
// Reset (arst_n low) restores register defaults, clears filters, counter
// and phase, and arms the filters to load the next sample directly.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once;
// indexes beyond the register list are ignored.
module accel_rep_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [arc_pkg::FIELD_W-1:0] accel_x,
	input  logic signed [arc_pkg::FIELD_W-1:0] accel_y,
	input  logic signed [arc_pkg::FIELD_W-1:0] accel_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [arc_pkg::FIELD_W-1:0]     rep_total,
	output logic [arc_pkg::FIELD_W-1:0]     magnitude,
	output logic [1:0]                      phase,
	input  logic                            cfg_we,
	input  logic [arc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [arc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import arc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQ   = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t              state_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [FIELD_W-1:0]  lift_q;
	logic [FIELD_W-1:0]  lower_q;
	logic [FIELD_W-1:0]  rest_lo_q;
	logic [FIELD_W-1:0]  rest_hi_q;
	logic                first_q;
	phase_t              phase_q;
	phase_t              phase_nx;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_nx;
	logic                out_valid_q;
	logic [FIELD_W-1:0]  rep_total_q;
	logic [FIELD_W-1:0]  magnitude_q;
	logic [1:0]          phase_out_q;

	logic                accept;
	logic                emit;
	logic [GAIN_W-1:0]   gain_eff;
	lane_ctrl_t          lane_ctrl;
	logic [FIELD_W-1:0]  samp [3];
	logic [SQ_W-1:0]     sq [3];
	logic [SUM_W-1:0]    sum;
	logic                sqrt_start;
	logic                sqrt_done;
	logic [RT_W-1:0]     root;
	logic [MAGF_W-1:0]   mag_full;
	logic [CMP_W-1:0]    mag_c;
	logic [CNT_EXT_W-1:0] cnt_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_W'(51);
			lift_q    <= FIELD_W'(5120);
			lower_q   <= FIELD_W'(3482);
			rest_lo_q <= FIELD_W'(3891);
			rest_hi_q <= FIELD_W'(4301);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:      gain_q    <= cfg_data[GAIN_W-1:0];
				REG_LIFT:      lift_q    <= cfg_data[FIELD_W-1:0];
				REG_LOWER:     lower_q   <= cfg_data[FIELD_W-1:0];
				REG_REST_LOW:  rest_lo_q <= cfg_data[FIELD_W-1:0];
				REG_REST_HIGH: rest_hi_q <= cfg_data[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// gains above unity behave as unity
	assign gain_eff = gain_q[GAIN_W-1] ? GAIN_W'(GAIN_ONE) : gain_q;

	assign lane_ctrl.load   = accept;
	assign lane_ctrl.first  = first_q;
	assign lane_ctrl.square = (state_q == ST_SQ);

	assign samp[0] = accel_x;
	assign samp[1] = accel_y;
	assign samp[2] = accel_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		arc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.gain   (gain_eff),
			.sample (samp[i]),
			.sq_s1  (sq[i])
		);
	end

	// merge the three lanes
	assign sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
	assign sqrt_start = (state_q == ST_SUM);

	arc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (RAD_W'(sum)),
		.done     (sqrt_done),
		.root     (root)
	);

	assign mag_full = root[RT_W-1:MAG_FRAC];
	assign mag_c    = CMP_W'(mag_full);

	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		case (phase_q)
			PH_LIFT: begin
				if (mag_c < CMP_W'(lower_q)) begin
					phase_nx = PH_LOWER;
				end
			end
			PH_LOWER: begin
				if (mag_c > CMP_W'(rest_lo_q) && mag_c < CMP_W'(rest_hi_q)) begin
					phase_nx = PH_IDLE;
					if (cnt_q != '1) begin
						cnt_nx = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				phase_nx = (mag_c > CMP_W'(lift_q)) ? PH_LIFT : PH_IDLE;
			end
		endcase
	end

	assign cnt_ext = CNT_EXT_W'(cnt_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b1;
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rep_total_q <= '0;
			magnitude_q <= '0;
			phase_out_q <= PH_IDLE;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_q <= 1'b0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sqrt_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (emit) begin
						phase_q     <= phase_nx;
						cnt_q       <= cnt_nx;
						rep_total_q <= (cnt_ext > CNT_EXT_W'({FIELD_W{1'b1}})) ?
							{FIELD_W{1'b1}} : cnt_ext[FIELD_W-1:0];
						magnitude_q <= (mag_c > CMP_W'({FIELD_W{1'b1}})) ?
							{FIELD_W{1'b1}} : mag_c[FIELD_W-1:0];
						phase_out_q <= phase_nx;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign rep_total = rep_total_q;
	assign magnitude = magnitude_q;
	assign phase     = phase_out_q;

endmodule

[sv/arc_lane.sv]
`timescale 1ns / 1ps
// One axis lane: low-pass filter register and squared magnitude.
module arc_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  arc_pkg::lane_ctrl_t        ctrl,
	input  logic [arc_pkg::GAIN_W-1:0] gain,
	input  logic [arc_pkg::FIELD_W-1:0] sample,
	output logic [arc_pkg::SQ_W-1:0]   sq_s1
);
	import arc_pkg::*;

	logic        [RAW_W-1:0]       raw;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [AXIS_BITS-1:0]   ext;
	logic signed [AXIS_BITS-1:0]   f_q;
	logic signed [AXIS_BITS:0]     diff;
	logic signed [GAIN_W:0]        gain_s;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      rnd;
	logic signed [PROD_W-1:0]      shr;
	logic signed [AXIS_BITS:0]     upd;
	logic signed [AXIS_BITS:0]     f_sum;
	logic signed [AXIS_BITS-1:0]   a_full;
	logic signed [AXIS_BITS-1:0]   a_neg;
	logic        [A_W-1:0]         a_abs;

	assign raw    = RAW_W'(sample);
	assign smp    = $signed(raw[SAMPLE_BITS-1:0]);
	assign ext    = AXIS_BITS'(smp) <<< FILTER_FRAC_BITS;
	assign diff   = (AXIS_BITS+1)'(ext) - (AXIS_BITS+1)'(f_q);
	assign gain_s = $signed({1'b0, gain});
	assign prod   = diff * gain_s;
	// round half up before dropping the gain fraction
	assign rnd    = prod + $signed(PROD_W'(GAIN_ONE / 2));
	assign shr    = rnd >>> GAIN_FRAC;
	assign upd    = shr[AXIS_BITS:0];
	assign f_sum  = (AXIS_BITS+1)'(f_q) + upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
		end else if (ctrl.load) begin
			if (ctrl.first) begin
				f_q <= ext;
			end else begin
				f_q <= f_sum[AXIS_BITS-1:0];
			end
		end
	end

	assign a_full = f_q >>> MAG_DROP;
	assign a_neg  = -a_full;
	assign a_abs  = a_full[AXIS_BITS-1] ? a_neg[A_W-1:0] : a_full[A_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.square) begin
			sq_s1 <= a_abs * a_abs;
		end
	end

endmodule

[sv/arc_sqrt.sv]
`timescale 1ns / 1ps
// Iterative integer square root, two root bits per cycle.
module arc_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [arc_pkg::RAD_W-1:0] radicand,
	output logic                      done,
	output logic [arc_pkg::RT_W-1:0]  root
);
	import arc_pkg::*;

	logic [RAD_W-1:0]      rad_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	sqrt_acc_t             acc_q;
	sqrt_acc_t             acc_mid;
	sqrt_acc_t             acc_nx;

	assign acc_mid = sqrt_step(acc_q, rad_q[RAD_W-1 -: 2]);
	assign acc_nx  = sqrt_step(acc_mid, rad_q[RAD_W-3 -: 2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(SQRT_CYC - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			acc_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-5:0], 4'b0000};
			acc_q <= acc_nx;
		end
	end

	assign done = done_q;
	assign root = acc_q.root;

endmodule

[sv/arc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the repetition counter, bound to the top level.
module arc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [arc_pkg::FIELD_W-1:0]     rep_total,
	input logic [arc_pkg::FIELD_W-1:0]     magnitude,
	input logic [1:0]                      phase
);
	import arc_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rep_total) &&
		$stable(magnitude) && $stable(phase))
		else $error("result word changed while stalled");

	// one sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while one is in flight");

	// the count only moves when lowering finishes back at idle
	a_count_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$stable(rep_total) |-> phase == PH_IDLE)
		else $error("repetition counted outside return to idle");

	// no result rises straight after a sample is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too soon after a sample");

endmodule

bind accel_rep_counter arc_checker u_arc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.rep_total (rep_total),
	.magnitude (magnitude),
	.phase     (phase)
);
